// File: rtl/assert_macros.svh
// Assertion macros shared by the odometry RTL.
// Each macro expects signals named clk and rst in the enclosing module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPLIES(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("odometry assertion failed");

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("odometry assertion failed");

`endif

// File: rtl/ddo_pkg.sv
// Package for the differential drive odometry block.
// Holds fixed-point constants, sequencer types and the CORDIC arctangent table.
package ddo_pkg;

  localparam int CORDIC_STEPS_DEF = 24;
  localparam int DIV_W = 42;

  localparam logic [1:0] REG_METRES_PER_PULSE  = 2'd0;
  localparam logic [1:0] REG_REVS_PER_PULSE    = 2'd1;
  localparam logic [1:0] REG_INVERSE_WHEELBASE = 2'd2;

  localparam logic signed [31:0] PI_Q       = 32'sd1686629713;
  localparam logic signed [31:0] HALF_PI_Q  = 32'sd843314857;
  localparam logic        [31:0] TWO_PI_Q   = 32'd3373259426;
  localparam logic signed [33:0] PI_Q34     = 34'sd1686629713;
  localparam logic signed [33:0] TWO_PI_Q34 = 34'sd3373259426;
  localparam logic signed [33:0] CORDIC_GAIN = 34'sh026DD3B6A;
  localparam logic        [31:0] SPEED_SCALE = 32'd1000;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MSTART,
    ST_MWAIT,
    ST_DWAIT,
    ST_CWAIT,
    ST_OUT
  } state_t;

  typedef enum logic [3:0] {
    OP_DIST_L,
    OP_DIST_R,
    OP_REVS_L,
    OP_REVS_R,
    OP_SPD_L,
    OP_SPD_R,
    OP_TURN,
    OP_POS_X,
    OP_POS_Y
  } op_t;

  function automatic logic [31:0] atan_q30(input logic [4:0] idx);
    logic [31:0] v;
    case (idx)
      5'd0:  v = 32'h3243F6A8;
      5'd1:  v = 32'h1DAC6705;
      5'd2:  v = 32'h0FADBAFC;
      5'd3:  v = 32'h07F56EA6;
      5'd4:  v = 32'h03FEAB76;
      5'd5:  v = 32'h01FFD55B;
      5'd6:  v = 32'h00FFFAAA;
      5'd7:  v = 32'h007FFF55;
      5'd8:  v = 32'h003FFFEA;
      5'd9:  v = 32'h001FFFFD;
      5'd10: v = 32'h000FFFFF;
      5'd11: v = 32'h0007FFFF;
      5'd12: v = 32'h0003FFFF;
      5'd13: v = 32'h0001FFFF;
      5'd14: v = 32'h0000FFFF;
      5'd15: v = 32'h00007FFF;
      5'd16: v = 32'h00003FFF;
      5'd17: v = 32'h00001FFF;
      5'd18: v = 32'h00000FFF;
      5'd19: v = 32'h000007FF;
      5'd20: v = 32'h000003FF;
      5'd21: v = 32'h000001FF;
      5'd22: v = 32'h000000FF;
      5'd23: v = 32'h0000007F;
      5'd24: v = 32'h0000003F;
      5'd25: v = 32'h0000001F;
      5'd26: v = 32'h0000000F;
      5'd27: v = 32'h00000008;
      5'd28: v = 32'h00000004;
      5'd29: v = 32'h00000002;
      5'd30: v = 32'h00000001;
      default: v = 32'h00000000;
    endcase
    return v;
  endfunction

endpackage

// File: rtl/ddo_mul.sv
// Shared unsigned 48 x 32 multiplier for the odometry block.
// Works in two 16-bit halves of the second operand, low half first.
module ddo_mul
  import ddo_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [47:0] a,
  input  logic [31:0] b,
  output logic        done,
  output logic [79:0] prod
);

  logic [47:0] a_r;
  logic [15:0] b_hi;
  logic [79:0] acc;
  logic        busy;
  logic [47:0] mul_a;
  logic [15:0] mul_b;
  logic [63:0] pp;

  assign mul_a = start ? a : a_r;
  assign mul_b = start ? b[15:0] : b_hi;
  assign pp    = 64'(mul_a) * 64'(mul_b);
  assign prod  = acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r  <= a;
      b_hi <= b[31:16];
      acc  <= {16'd0, pp};
    end else if (busy) begin
      acc <= acc + {pp, 16'd0};
    end
  end

endmodule

// File: rtl/ddo_div.sv
// Restoring divider for the wheel speed quotient, one quotient bit a cycle.
// Uses the dividend width from ddo_pkg.
module ddo_div
  import ddo_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [DIV_W-1:0] dividend,
  input  logic [15:0]      divisor,
  output logic             done,
  output logic [DIV_W-1:0] quotient
);

  localparam int CW = $clog2(DIV_W);
  localparam logic [CW-1:0] LAST = CW'(DIV_W - 1);

  logic [DIV_W-1:0] quo;
  logic [15:0]      dvs;
  logic [16:0]      rem;
  logic [CW-1:0]    cnt;
  logic             busy;
  logic [16:0]      shifted;
  logic [17:0]      trial;

  assign shifted  = {rem[15:0], quo[DIV_W-1]};
  assign trial    = {1'b0, shifted} - {2'b00, dvs};
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == LAST) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      dvs <= divisor;
      rem <= 17'd0;
      cnt <= '0;
    end else if (busy) begin
      cnt <= cnt + 1'b1;
      if (!trial[17]) begin
        rem <= trial[16:0];
        quo <= {quo[DIV_W-2:0], 1'b1};
      end else begin
        rem <= shifted;
        quo <= {quo[DIV_W-2:0], 1'b0};
      end
    end
  end

endmodule

// File: rtl/ddo_cordic.sv
// Rotation-mode CORDIC giving cosine and sine of the heading, one step a cycle.
// Uses the arctangent table and angle constants from ddo_pkg.
module ddo_cordic
  import ddo_pkg::*;
#(
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [31:0] angle,
  output logic               done,
  output logic signed [33:0] cos_out,
  output logic signed [33:0] sin_out
);

  localparam int IW = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;
  localparam logic [IW-1:0] LAST = IW'(CORDIC_STEPS - 1);

  logic signed [33:0] x, y, z;
  logic signed [33:0] xs, ys, at;
  logic signed [32:0] a33, folded;
  logic [IW-1:0]      i;
  logic               busy;
  logic               neg;
  logic               fold_neg;

  assign a33 = {angle[31], angle};
  assign xs  = x >>> i;
  assign ys  = y >>> i;
  assign at  = $signed({2'b00, atan_q30(5'(i))});

  always_comb begin
    if (angle > HALF_PI_Q) begin
      folded   = a33 - {PI_Q[31], PI_Q};
      fold_neg = 1'b1;
    end else if (angle < -HALF_PI_Q) begin
      folded   = a33 + {PI_Q[31], PI_Q};
      fold_neg = 1'b1;
    end else begin
      folded   = a33;
      fold_neg = 1'b0;
    end
  end

  assign cos_out = neg ? -x : x;
  assign sin_out = neg ? -y : y;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && i == LAST) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x   <= CORDIC_GAIN;
      y   <= 34'sd0;
      z   <= {folded, 1'b0};
      neg <= fold_neg;
      i   <= '0;
    end else if (busy) begin
      i <= i + 1'b1;
      if (!z[33]) begin
        x <= x - ys;
        y <= y + xs;
        z <= z - at;
      end else begin
        x <= x + ys;
        y <= y - xs;
        z <= z + at;
      end
    end
  end

endmodule

// File: rtl/differential_drive_odometry.sv
// Differential drive odometry top level: sequencer, pose state and config registers.
// Depends on ddo_pkg, assert_macros.svh, ddo_mul, ddo_div and ddo_cordic.
//
// Usage. Input beats carry left_pulses, right_pulses and elapsed_ms on a
// valid/ready channel; every input beat produces exactly one output beat on a
// valid/ready channel carrying the full odometry state and the updated flag.
// The block takes one beat at a time: in_ready is high only while it is idle.
// A beat with zero elapsed time only folds the pulses into the pending sums;
// its result is offered in the cycle after acceptance. Any other beat runs nine
// products in turn through one shared 48 x 32 multiplier, with a division of
// 42 quotient bits after each of the two wheel speed products and one CORDIC
// pass of CORDIC_STEPS steps after the turn product; its result is offered
// once the last position product is done.
// The result holds on the output ports until out_ready is seen; while the
// receiver stalls no new beat is taken, and in_ready rises the cycle after
// the output beat is accepted.
// Configuration writes take effect at once and belong to idle periods.
// Reset clears the configuration, accumulators, pose and state and sets the heading to pi over two.
module differential_drive_odometry
  import ddo_pkg::*;
#(
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [15:0] left_pulses,
  input  logic signed [15:0] right_pulses,
  input  logic [15:0]        elapsed_ms,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               updated,
  output logic signed [31:0] left_speed,
  output logic signed [31:0] right_speed,
  output logic signed [47:0] left_distance,
  output logic signed [47:0] right_distance,
  output logic [47:0]        left_revolutions,
  output logic [47:0]        right_revolutions,
  output logic signed [47:0] pose_x,
  output logic signed [47:0] pose_y,
  output logic signed [31:0] heading
);

`include "assert_macros.svh"

  state_t state, state_next;
  op_t    op;

  logic [31:0] metres_per_pulse, revs_per_pulse, inverse_wheelbase;
  logic [15:0] pending_left, pending_right;
  logic [31:0] left_speed_held, right_speed_held;
  logic [47:0] left_distance_acc, right_distance_acc;
  logic [47:0] left_revs_acc, right_revs_acc;
  logic [47:0] pos_x, pos_y;
  logic [31:0] angle;
  logic        updated_r;

  logic [15:0] pl, pr, elapsed_r;
  logic [47:0] prod_mag_l, prod_mag_r;
  logic [40:0] dl, dr;
  logic [31:0] c_mag, s_mag;
  logic        c_neg, s_neg;

  logic        mul_start, mul_done, div_start, div_done, cor_start, cor_done;
  logic [47:0] mul_a;
  logic [31:0] mul_b;
  logic [79:0] prod;
  logic [DIV_W-1:0] div_q;
  logic signed [33:0] cor_cos, cor_sin;

  logic [15:0] sum_l, sum_r;
  logic [16:0] abs_l, abs_r;
  logic [41:0] diff, diff_mag, msum;
  logic [40:0] mean, mean_mag;
  logic        cur_neg;
  logic [48:0] dist_s, dist_t;
  logic [47:0] dist_ext;
  logic [47:0] rev_round, rev_inc, rev_cur, rev_sat;
  logic [48:0] rev_tot;
  logic [31:0] speed_new;
  logic [60:0] turn_mag;
  logic [31:0] turn_clip;
  logic [33:0] dth, h_sum, h_wrap;
  logic [47:0] pos_mag, pos_delta;
  logic        pos_neg;
  logic [33:0] cos_neg_v, sin_neg_v;
  op_t         op_inc;

  assign sum_l = pending_left + left_pulses;
  assign sum_r = pending_right + right_pulses;
  assign abs_l = pl[15] ? 17'd0 - {pl[15], pl} : {1'b0, pl};
  assign abs_r = pr[15] ? 17'd0 - {pr[15], pr} : {1'b0, pr};
  assign diff     = {dr[40], dr} - {dl[40], dl};
  assign diff_mag = diff[41] ? 42'd0 - diff : diff;
  assign msum     = {dr[40], dr} + {dl[40], dl};
  assign mean     = msum[41:1];
  assign mean_mag = mean[40] ? 41'd0 - mean : mean;
  assign op_inc   = op_t'(op + 4'd1);

  always_comb begin
    case (op)
      OP_DIST_L: begin mul_a = 48'(abs_l);    mul_b = metres_per_pulse;  end
      OP_DIST_R: begin mul_a = 48'(abs_r);    mul_b = metres_per_pulse;  end
      OP_REVS_L: begin mul_a = 48'(abs_l);    mul_b = revs_per_pulse;    end
      OP_REVS_R: begin mul_a = 48'(abs_r);    mul_b = revs_per_pulse;    end
      OP_SPD_L:  begin mul_a = prod_mag_l;    mul_b = SPEED_SCALE;       end
      OP_SPD_R:  begin mul_a = prod_mag_r;    mul_b = SPEED_SCALE;       end
      OP_TURN:   begin mul_a = 48'(diff_mag); mul_b = inverse_wheelbase; end
      OP_POS_X:  begin mul_a = 48'(mean_mag); mul_b = c_mag;             end
      OP_POS_Y:  begin mul_a = 48'(mean_mag); mul_b = s_mag;             end
      default:   begin mul_a = 48'd0;         mul_b = 32'd0;             end
    endcase
  end

  assign cur_neg = (op == OP_DIST_L || op == OP_REVS_L || op == OP_SPD_L) ? pl[15] : pr[15];

  assign dist_s   = cur_neg ? 49'd0 - {1'b0, prod[47:0]} : {1'b0, prod[47:0]};
  assign dist_t   = dist_s + 49'd128;
  assign dist_ext = {{7{dist_t[48]}}, dist_t[48:8]};

  assign rev_round = prod[47:0] + 48'd128;
  assign rev_inc   = {8'd0, rev_round[47:8]};
  assign rev_cur   = (op == OP_REVS_L) ? left_revs_acc : right_revs_acc;
  assign rev_tot   = {1'b0, rev_cur} + {1'b0, rev_inc};
  assign rev_sat   = rev_tot[48] ? {48{1'b1}} : rev_tot[47:0];

  always_comb begin
    if (cur_neg) begin
      if (div_q >= 42'h080000000) begin
        speed_new = 32'h80000000;
      end else begin
        speed_new = 32'd0 - div_q[31:0];
      end
    end else begin
      if (div_q >= 42'h07FFFFFFF) begin
        speed_new = 32'h7FFFFFFF;
      end else begin
        speed_new = div_q[31:0];
      end
    end
  end

  assign turn_mag  = prod[79:19];
  assign turn_clip = (turn_mag > 61'(TWO_PI_Q)) ? TWO_PI_Q : turn_mag[31:0];
  assign dth       = diff[41] ? 34'd0 - {2'b00, turn_clip} : {2'b00, turn_clip};
  assign h_sum     = {{2{angle[31]}}, angle} + dth;

  always_comb begin
    if ($signed(h_sum) > PI_Q34) begin
      h_wrap = h_sum - TWO_PI_Q34;
    end else if ($signed(h_sum) < -PI_Q34) begin
      h_wrap = h_sum + TWO_PI_Q34;
    end else begin
      h_wrap = h_sum;
    end
  end

  assign pos_mag   = prod[77:30];
  assign pos_neg   = mean[40] ^ ((op == OP_POS_X) ? c_neg : s_neg);
  assign pos_delta = pos_neg ? 48'd0 - pos_mag : pos_mag;
  assign cos_neg_v = 34'd0 - cor_cos;
  assign sin_neg_v = 34'd0 - cor_sin;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = (elapsed_ms == 16'd0) ? ST_OUT : ST_MSTART;
        end
      end
      ST_MSTART: state_next = ST_MWAIT;
      ST_MWAIT: begin
        if (mul_done) begin
          case (op)
            OP_SPD_L, OP_SPD_R: state_next = ST_DWAIT;
            OP_TURN:            state_next = ST_CWAIT;
            OP_POS_Y:           state_next = ST_OUT;
            default:            state_next = ST_MSTART;
          endcase
        end
      end
      ST_DWAIT: if (div_done) state_next = ST_MSTART;
      ST_CWAIT: if (cor_done) state_next = ST_MSTART;
      ST_OUT:   if (out_ready) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = (state == ST_IDLE);
    out_valid = (state == ST_OUT);
    mul_start = (state == ST_MSTART);
    div_start = (state == ST_MWAIT) && mul_done && (op == OP_SPD_L || op == OP_SPD_R);
    cor_start = (state == ST_MWAIT) && mul_done && (op == OP_TURN);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      metres_per_pulse   <= 32'd0;
      revs_per_pulse     <= 32'd0;
      inverse_wheelbase  <= 32'd0;
      pending_left       <= 16'd0;
      pending_right      <= 16'd0;
      left_speed_held    <= 32'd0;
      right_speed_held   <= 32'd0;
      left_distance_acc  <= 48'd0;
      right_distance_acc <= 48'd0;
      left_revs_acc      <= 48'd0;
      right_revs_acc     <= 48'd0;
      pos_x              <= 48'd0;
      pos_y              <= 48'd0;
      angle              <= HALF_PI_Q;
      updated_r          <= 1'b0;
      op                 <= OP_DIST_L;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          REG_METRES_PER_PULSE:  metres_per_pulse  <= cfg_data;
          REG_REVS_PER_PULSE:    revs_per_pulse    <= cfg_data;
          REG_INVERSE_WHEELBASE: inverse_wheelbase <= cfg_data;
          default: ;
        endcase
      end
      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            pl        <= sum_l;
            pr        <= sum_r;
            elapsed_r <= elapsed_ms;
            op        <= OP_DIST_L;
            if (elapsed_ms == 16'd0) begin
              pending_left  <= sum_l;
              pending_right <= sum_r;
              updated_r     <= 1'b0;
            end else begin
              pending_left  <= 16'd0;
              pending_right <= 16'd0;
              updated_r     <= 1'b1;
            end
          end
        end
        ST_MWAIT: begin
          if (mul_done) begin
            case (op)
              OP_DIST_L: begin
                prod_mag_l        <= prod[47:0];
                dl                <= dist_t[48:8];
                left_distance_acc <= left_distance_acc + dist_ext;
              end
              OP_DIST_R: begin
                prod_mag_r         <= prod[47:0];
                dr                 <= dist_t[48:8];
                right_distance_acc <= right_distance_acc + dist_ext;
              end
              OP_REVS_L: left_revs_acc  <= rev_sat;
              OP_REVS_R: right_revs_acc <= rev_sat;
              OP_TURN:   angle <= h_wrap[31:0];
              OP_POS_X:  pos_x <= pos_x + pos_delta;
              OP_POS_Y:  pos_y <= pos_y + pos_delta;
              default: ;
            endcase
            if (op != OP_SPD_L && op != OP_SPD_R && op != OP_TURN) begin
              op <= op_inc;
            end
          end
        end
        ST_DWAIT: begin
          if (div_done) begin
            if (op == OP_SPD_L) begin
              left_speed_held <= speed_new;
            end else begin
              right_speed_held <= speed_new;
            end
            op <= op_inc;
          end
        end
        ST_CWAIT: begin
          if (cor_done) begin
            c_neg <= cor_cos[33];
            s_neg <= cor_sin[33];
            c_mag <= cor_cos[33] ? cos_neg_v[31:0] : cor_cos[31:0];
            s_mag <= cor_sin[33] ? sin_neg_v[31:0] : cor_sin[31:0];
            op    <= op_inc;
          end
        end
        default: ;
      endcase
    end
  end

  ddo_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .prod  (prod)
  );

  ddo_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (prod[57:16]),
    .divisor  (elapsed_r),
    .done     (div_done),
    .quotient (div_q)
  );

  ddo_cordic #(
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_cordic (
    .clk     (clk),
    .rst     (rst),
    .start   (cor_start),
    .angle   (h_wrap[31:0]),
    .done    (cor_done),
    .cos_out (cor_cos),
    .sin_out (cor_sin)
  );

  assign updated           = updated_r;
  assign left_speed        = left_speed_held;
  assign right_speed       = right_speed_held;
  assign left_distance     = left_distance_acc;
  assign right_distance    = right_distance_acc;
  assign left_revolutions  = left_revs_acc;
  assign right_revolutions = right_revs_acc;
  assign pose_x            = pos_x;
  assign pose_y            = pos_y;
  assign heading           = angle;

  `ASSERT_NEXT(a_defer_fast, in_valid && in_ready && elapsed_ms == 16'd0, out_valid && !updated)
  `ASSERT_IMPLIES(a_heading_range, out_valid, (heading <= PI_Q) && (heading >= -PI_Q))
  `ASSERT_IMPLIES(a_mul_done_state, mul_done, state == ST_MWAIT)

endmodule
